[design/pale_pkg.sv]
// ----------------------------------------------------------------------------
// pale_pkg
// Shared types and codes for the positional array list engine: request and
// result transaction layouts, operation codes, status codes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pale_pkg;

  // Default number of list entries
  localparam int unsigned PALE_CAPACITY = 128;

  // Operation codes
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_WRITE  = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Request transaction
  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         position;
    logic signed [31:0] value;
  } pale_req_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [7:0]         count;
  } pale_rsp_t;

endpackage

[design/positional_array_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// positional_array_list_engine_unit
// Packed ordered list of signed words held in a single-port-write,
// single-port-read synchronous memory, with append, insert, delete, read
// and write by 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Exactly
//   one result follows: done_o is high for one cycle with rsp_o valid, and
//   the receiver must take it then (there is no back pressure).
//   Append, write and any failing request finish in the execute state;
//   read, insert and delete go on through the shift and finish states.
//   Insert and delete move one entry per cycle through the memory: a read
//   of entry k and the write of the previous entry overlap, and the last
//   write drains as the shift ends.
//   Busy stays high from acceptance until the result cycle; a new request
//   may be taken in the cycle that carries the result.
//   Reset clears the list length to zero; memory contents are left as they
//   are, since only entries below the length are ever read. No clearing
//   pass is needed, so requests are accepted right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_array_list_engine_unit #(
  parameter int unsigned CAPACITY = pale_pkg::PALE_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pale_pkg::pale_req_t req_i,
  output logic                done_o,
  output pale_pkg::pale_rsp_t rsp_o
);

  import pale_pkg::*;

  // Widths: memory index, list length, and a common compare width
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > 8) ? LW : 8;

  // State codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state_q, state_d;
  pale_req_t          req_q, req_d;
  logic [LW-1:0]      len_q, len_d;
  logic [LW-1:0]      rem_q, rem_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic [AW-1:0]      wr_idx_q, wr_idx_d;
  logic               pend_q, pend_d;
  logic               cap_q, cap_d;
  logic               first_q, first_d;
  logic signed [31:0] got_q, got_d;
  logic               done_q, done_d;
  pale_rsp_t          rsp_q, rsp_d;

  // Memory ports
  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata;

  // Decode helpers
  logic [CW-1:0]      pos_c, len_c, pos_m1_c, len_m1_c, span_c;
  logic               pos_ok, full, is_ins;

  assign pos_c    = CW'(req_q.position);
  assign len_c    = CW'(len_q);
  assign pos_m1_c = pos_c - CW'(1);
  assign len_m1_c = len_c - CW'(1);
  assign span_c   = len_c - pos_c + CW'(1);
  assign pos_ok   = (pos_c != '0) && (pos_c <= len_c);
  assign full     = (len_q == LW'(CAPACITY));
  assign is_ins   = (req_q.mode == MODE_INSERT);

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Control and sequencing
  always_comb begin
    logic [CW-1:0] len_ext;
    state_d   = state_q;
    req_d     = req_q;
    len_d     = len_q;
    rem_d     = rem_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    pend_d    = 1'b0;
    cap_d     = 1'b0;
    first_d   = first_q;
    got_d     = got_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    len_ext   = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rsp_d.data   = '0;
        rsp_d.status = STATUS_OK;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
        case (req_q.mode)
          MODE_APPEND: begin
            if (full) begin
              rsp_d.status = STATUS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = len_q[AW-1:0];
              mem_wdata = req_q.value;
              len_d     = len_q + LW'(1);
            end
          end
          MODE_INSERT: begin
            if (!pos_ok) begin
              rsp_d.status = STATUS_RANGE;
            end else if (full) begin
              rsp_d.status = STATUS_FULL;
            end else begin
              done_d   = 1'b0;
              state_d  = ST_SHIFT;
              rem_d    = span_c[LW-1:0];
              rd_idx_d = len_m1_c[AW-1:0];
              first_d  = 1'b0;
            end
          end
          MODE_DELETE, MODE_READ: begin
            if (!pos_ok) begin
              rsp_d.status = STATUS_RANGE;
            end else begin
              done_d   = 1'b0;
              state_d  = ST_SHIFT;
              rem_d    = (req_q.mode == MODE_READ) ? LW'(1) : span_c[LW-1:0];
              rd_idx_d = pos_m1_c[AW-1:0];
              first_d  = 1'b1;
            end
          end
          MODE_WRITE: begin
            if (!pos_ok) begin
              rsp_d.status = STATUS_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pos_m1_c[AW-1:0];
              mem_wdata = req_q.value;
            end
          end
          default: begin
            rsp_d.status = STATUS_RANGE;
          end
        endcase
        len_ext       = CW'(len_d);
        rsp_d.count   = len_ext[7:0];
      end

      ST_SHIFT: begin
        // Issue the next read; its data lands in the next cycle
        if (rem_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rd_idx_q;
          rem_d     = rem_q - LW'(1);
          pend_d    = 1'b1;
          cap_d     = first_q;
          first_d   = 1'b0;
          rd_idx_d  = is_ins ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
          wr_idx_d  = is_ins ? (rd_idx_q + AW'(1)) : (rd_idx_q - AW'(1));
        end else begin
          state_d = ST_FINISH;
        end
        // Retire the previous read: capture the target or move the entry
        if (pend_q) begin
          if (cap_q) begin
            got_d = rdata_q;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_q;
            mem_wdata = rdata_q;
          end
        end
      end

      ST_FINISH: begin
        rsp_d.status = STATUS_OK;
        rsp_d.data   = is_ins ? '0 : got_q;
        if (is_ins) begin
          mem_we    = 1'b1;
          mem_waddr = pos_m1_c[AW-1:0];
          mem_wdata = req_q.value;
          len_d     = len_q + LW'(1);
        end else if (req_q.mode == MODE_DELETE) begin
          len_d = len_q - LW'(1);
        end
        len_ext     = CW'(len_d);
        rsp_d.count = len_ext[7:0];
        done_d      = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      cap_q   <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      cap_q   <= cap_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    got_q    <= got_d;
    rsp_q    <= rsp_d;
  end

  // List memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

[verif/positional_array_list_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// positional_array_list_engine_unit_tb
// Self-checking bench for the positional array list engine. A local mirror of
// the list predicts each result as a request transaction is accepted.
// Stimulus runs in phases: edge cases on a short list, a fill to capacity
// with the list-full refusals, a long random mix that steers the list length
// between empty and full, and a drain back to empty. Random idle gaps
// separate requests. Every result transaction is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_array_list_engine_unit_tb;
  import pale_pkg::*;

  localparam int CAP = PALE_CAPACITY;
  localparam int RANDOM_ITEMS = 1100;

  // Mode codes the engine does not implement
  localparam logic [2:0] MODE_UNUSED_A = 3'd5;
  localparam logic [2:0] MODE_UNUSED_B = 3'd6;
  localparam logic [2:0] MODE_UNUSED_C = 3'd7;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  pale_req_t req_i;
  logic      done_o;
  pale_rsp_t rsp_o;

  // Mirror of the list contents and length
  logic signed [31:0] list_mirror [CAP];
  int                 mirror_len;

  pale_rsp_t expected_outcomes [$];

  int error_count;
  int results_checked;
  int full_refusals;
  int peak_len;
  int op_count [8];
  int fill_goal;
  bit no_idle;

  positional_array_list_engine_unit #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // Clock: 8 ns period
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the engine hangs
  initial begin
    #20_000_000;
    $display("positional_array_list_engine_unit_tb: errors");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t ns MISMATCH: %s", $time, msg);
    end
  endtask

  function automatic bit pos_in_list(int p);
    return (p >= 1) && (p <= mirror_len);
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic pale_rsp_t apply_list_op(pale_req_t r);
    pale_rsp_t o;
    int        p;
    int        k;
    o.status = STATUS_OK;
    o.data   = '0;
    p        = int'(r.position);
    case (r.mode)
      MODE_APPEND: begin
        if (mirror_len >= CAP) begin
          o.status = STATUS_FULL;
        end else begin
          list_mirror[mirror_len] = r.value;
          mirror_len++;
        end
      end
      MODE_INSERT: begin
        // range check wins over the full check
        if (!pos_in_list(p)) begin
          o.status = STATUS_RANGE;
        end else if (mirror_len >= CAP) begin
          o.status = STATUS_FULL;
        end else begin
          for (k = mirror_len; k >= p; k--) list_mirror[k] = list_mirror[k - 1];
          list_mirror[p - 1] = r.value;
          mirror_len++;
        end
      end
      MODE_DELETE: begin
        if (!pos_in_list(p)) begin
          o.status = STATUS_RANGE;
        end else begin
          o.data = list_mirror[p - 1];
          for (k = p; k < mirror_len; k++) list_mirror[k - 1] = list_mirror[k];
          mirror_len--;
        end
      end
      MODE_READ: begin
        if (!pos_in_list(p)) o.status = STATUS_RANGE;
        else o.data = list_mirror[p - 1];
      end
      MODE_WRITE: begin
        if (!pos_in_list(p)) o.status = STATUS_RANGE;
        else list_mirror[p - 1] = r.value;
      end
      default: begin
        o.status = STATUS_RANGE;
      end
    endcase
    o.count = mirror_len[7:0];
    return o;
  endfunction

  function automatic pale_req_t mk_req(logic [2:0] m, logic [7:0] p, logic [31:0] v);
    pale_req_t r;
    r.mode     = m;
    r.position = p;
    r.value    = v;
    return r;
  endfunction

  // Mostly no gap, some short gaps, a few long ones; none while no_idle is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 3) return WORD_MIN;
    if (r < 6) return WORD_MAX;
    if (r < 8) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_valid_pos();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'd1;
    if (r < 30) return mirror_len[7:0];
    return 8'($urandom_range(mirror_len, 1));
  endfunction

  // Drive one request, hold it until accepted, then record its outcome
  task automatic send_request(pale_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_outcomes.push_back(apply_list_op(r));
    op_count[r.mode]++;
    if (mirror_len > peak_len) peak_len = mirror_len;
  endtask

  // Result checker
  pale_rsp_t want_rsp;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%0d count=%0d",
                                  rsp_o.status, rsp_o.data, rsp_o.count));
      end else begin
        want_rsp = expected_outcomes.pop_front();
        results_checked++;
        if (rsp_o.status == STATUS_FULL) full_refusals++;
        if (rsp_o.status !== want_rsp.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_o.status, want_rsp.status));
        if (rsp_o.data !== want_rsp.data)
          report_mismatch($sformatf("data got %0d want %0d", rsp_o.data, want_rsp.data));
        if (rsp_o.count !== want_rsp.count)
          report_mismatch($sformatf("count got %0d want %0d", rsp_o.count, want_rsp.count));
      end
    end
  end

  // Edge cases on an empty and a short list
  task automatic test_short_list_edges();
    send_request(mk_req(MODE_READ, 8'd1, 32'h1111_1111));
    send_request(mk_req(MODE_DELETE, 8'd1, '0));
    send_request(mk_req(MODE_WRITE, 8'd0, 32'h2222_2222));
    send_request(mk_req(MODE_INSERT, 8'd1, 32'h3333_3333));
    send_request(mk_req(MODE_APPEND, 8'hFF, WORD_MIN));
    send_request(mk_req(MODE_APPEND, 8'd0, WORD_MAX));
    send_request(mk_req(MODE_APPEND, 8'd7, '0));
    send_request(mk_req(MODE_INSERT, 8'd1, '1));
    send_request(mk_req(MODE_INSERT, 8'd4, 32'h5A5A_5A5A));
    send_request(mk_req(MODE_INSERT, 8'd6, 32'h0F0F_0F0F));
    send_request(mk_req(MODE_INSERT, 8'd0, 32'h0F0F_0F0F));
    send_request(mk_req(MODE_READ, 8'd1, '0));
    send_request(mk_req(MODE_READ, 8'd5, '0));
    send_request(mk_req(MODE_WRITE, 8'd3, 32'hA5A5_A5A5));
    send_request(mk_req(MODE_READ, 8'd3, '0));
    send_request(mk_req(MODE_WRITE, 8'd6, 32'h1234_5678));
    send_request(mk_req(MODE_DELETE, 8'd5, '0));
    send_request(mk_req(MODE_DELETE, 8'd1, '0));
    send_request(mk_req(MODE_READ, 8'hFF, '0));
    send_request(mk_req(MODE_READ, 8'd0, '0));
    send_request(mk_req(MODE_UNUSED_A, 8'd1, 32'hDEAD_BEEF));
    send_request(mk_req(MODE_UNUSED_B, 8'd1, 32'hDEAD_BEEF));
    send_request(mk_req(MODE_UNUSED_C, 8'd2, 32'hDEAD_BEEF));
    send_request(mk_req(MODE_DELETE, 8'd2, '0));
  endtask

  // Fill to capacity, then the refusals and shifts across a full list
  task automatic test_fill_to_capacity();
    int i;
    while (mirror_len < CAP) send_request(mk_req(MODE_APPEND, 8'($urandom), pick_word()));
    send_request(mk_req(MODE_APPEND, 8'd1, pick_word()));
    send_request(mk_req(MODE_INSERT, 8'd1, pick_word()));
    send_request(mk_req(MODE_INSERT, 8'(CAP), pick_word()));
    send_request(mk_req(MODE_INSERT, 8'd0, pick_word()));
    send_request(mk_req(MODE_INSERT, 8'(CAP + 1), pick_word()));
    send_request(mk_req(MODE_READ, 8'(CAP), '0));
    send_request(mk_req(MODE_WRITE, 8'(CAP), pick_word()));
    send_request(mk_req(MODE_DELETE, 8'd1, '0));
    send_request(mk_req(MODE_INSERT, 8'd1, pick_word()));
    send_request(mk_req(MODE_DELETE, 8'(CAP), '0));
    send_request(mk_req(MODE_INSERT, 8'(CAP - 1), pick_word()));
    for (i = 0; i < 10; i++) begin
      send_request(mk_req(MODE_READ, pick_valid_pos(), '0));
    end
    // shrink partway with deletes anywhere in the list
    for (i = 0; i < 40; i++) begin
      send_request(mk_req(MODE_DELETE, pick_valid_pos(), '0));
    end
  endtask

  function automatic pale_req_t make_random_req();
    int         r;
    logic [2:0] m;
    bit         grow;
    r = $urandom_range(99);
    // noise: any mode, any position
    if (r < 8) begin
      return mk_req(3'($urandom_range(MODE_UNUSED_C)), 8'($urandom), $urandom);
    end
    grow = (mirror_len < fill_goal);
    r = $urandom_range(99);
    if (r < 20) m = MODE_READ;
    else if (r < 35) m = MODE_WRITE;
    else if (r < 95) m = grow ? (r[0] ? MODE_APPEND : MODE_INSERT) : MODE_DELETE;
    else m = grow ? MODE_DELETE : MODE_APPEND;
    if (mirror_len == 0 && m != MODE_APPEND) m = MODE_APPEND;
    if (m == MODE_APPEND) return mk_req(m, 8'($urandom), pick_word());
    return mk_req(m, pick_valid_pos(), pick_word());
  endfunction

  // Long random mix with the length steered between extremes
  task automatic test_random_mix();
    int i;
    int r;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 120 == 0) begin
        r = $urandom_range(3);
        if (r == 0) fill_goal = 3;
        else if (r == 1) fill_goal = CAP;
        else fill_goal = $urandom_range(CAP);
        no_idle = ($urandom_range(3) == 0);
      end
      send_request(make_random_req());
    end
    no_idle = 1'b0;
  endtask

  // Empty the list, then probe the empty case once more
  task automatic test_drain_to_empty();
    while (mirror_len > 0) send_request(mk_req(MODE_DELETE, pick_valid_pos(), '0));
    send_request(mk_req(MODE_DELETE, 8'd1, '0));
    send_request(mk_req(MODE_WRITE, 8'd1, pick_word()));
    send_request(mk_req(MODE_APPEND, 8'd0, pick_word()));
    send_request(mk_req(MODE_READ, 8'd1, '0));
  endtask

  initial begin
    int sent;
    start       = 1'b0;
    req_i       = '0;
    rst_ni      = 1'b0;
    mirror_len  = 0;
    error_count = 0;
    fill_goal   = CAP / 2;
    no_idle     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_list_edges();
    test_fill_to_capacity();
    test_random_mix();
    test_drain_to_empty();

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (2 * CAP) @(posedge clk_i);

    sent = 0;
    foreach (op_count[i]) sent += op_count[i];
    $display("Run covered %0d requests: append %0d, insert %0d, delete %0d, read %0d, write %0d,",
             sent, op_count[MODE_APPEND], op_count[MODE_INSERT], op_count[MODE_DELETE],
             op_count[MODE_READ], op_count[MODE_WRITE]);
    $display("  unused modes %0d; %0d results checked, %0d list-full refusals, peak length %0d",
             sent - op_count[MODE_APPEND] - op_count[MODE_INSERT] - op_count[MODE_DELETE]
             - op_count[MODE_READ] - op_count[MODE_WRITE],
             results_checked, full_refusals, peak_len);
    if (error_count == 0) begin
      $display("positional_array_list_engine_unit_tb: clean");
    end else begin
      $display("positional_array_list_engine_unit_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pale_pkg.sv
design/positional_array_list_engine_unit.sv
verif/positional_array_list_engine_unit_tb.sv
